// ===== hw/rtl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Shared types and constants for the escape-time iteration block.
// ----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

    // Coordinate word and iteration counter widths are fixed by the port fields
    localparam int COORD_W = 32;
    localparam int ITER_W  = 16;

    localparam logic [ITER_W-1:0] LIMIT_RESET = 16'd256;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
    } t_point;

    typedef struct packed {
        logic              escaped;
        logic [ITER_W-1:0] iteration_count;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic escape;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Escape-time iteration of z = z*z + c for one point per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive i_point and pulse start while busy is low; the point is
//   taken at that edge and busy rises on the next cycle.
//   Result: o_done is high for exactly one cycle with o_result; the receiver
//   cannot hold it off, so it must take it then. busy is low again in the
//   same cycle, so a new request may be issued alongside the strobe.
//   Iteration: each iteration is one pass of the product/sum loop, an add
//   step and then a square step, after the seed has been squared. A point
//   that stays inside for the whole iteration limit (default 256) strobes
//   with escaped 0 and a count of zero.
//   Configuration: i_cfg_data written when i_cfg_valid and o_cfg_ready are
//   high; ready is high while no request is in flight. A limit of zero
//   gives escaped 0 without running any iteration.
//   Reset: synchronous, active low; clears the controller and sets the
//   iteration limit to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_top #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire met_pkg::t_point            i_point,
    output logic                            o_done,
    output met_pkg::t_result                o_result,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [met_pkg::ITER_W-1:0] i_cfg_data
);

    logic [met_pkg::ITER_W-1:0] r_limit;
    met_pkg::t_dp_cmd           cmd;
    met_pkg::t_dp_sts           sts;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= met_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    met_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_limit  (r_limit),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    met_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_point (i_point),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/met_dp.sv =====
// ----------------------------------------------------------------------------
// met_dp
// Datapath: holds c and z, forms the three saturated products and the
// saturated sums, and flags when the squared magnitude passes 4.
// ----------------------------------------------------------------------------
`default_nettype none

module met_dp #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic            i_clk,
    input  wire met_pkg::t_point i_point,
    input  wire met_pkg::t_dp_cmd i_cmd,
    output met_pkg::t_dp_sts     o_sts
);

    localparam int W     = met_pkg::COORD_W;
    localparam int CMP_W = (FRAC_BITS + 3 > W + 1) ? FRAC_BITS + 3 : W + 1;
    localparam logic [2*W-1:0]   MAX_MAG = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [CMP_W-1:0] BOUND   = CMP_W'(4) << FRAC_BITS;

    logic signed [W-1:0] r_cr, r_ci, r_zr, r_zi, r_zr2, r_zi2, r_zri;
    logic signed [W-1:0] n_zr, n_zi, diff;
    logic [CMP_W-1:0]    mag2;

    // |a*b| >> shift, truncated toward zero, clamped, sign restored
    function automatic logic signed [W-1:0] fx_mul(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b,
        input logic                dbl
    );
        logic           neg;
        logic [W-1:0]   ma, mb, mag;
        logic [2*W-1:0] prod, q, lim;
        neg  = a[W-1] ^ b[W-1];
        ma   = a[W-1] ? W'(-a) : W'(a);
        mb   = b[W-1] ? W'(-b) : W'(b);
        prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
        q    = dbl ? (prod >> (FRAC_BITS - 1)) : (prod >> FRAC_BITS);
        lim  = MAX_MAG + {{(2*W-1){1'b0}}, neg};
        if (q > lim) begin
            q = lim;
        end
        mag = q[W-1:0];
        fx_mul = neg ? $signed(W'(0) - mag) : $signed(mag);
    endfunction

    // clamp a W+1 bit sum back into W bits
    function automatic logic signed [W-1:0] sat(input logic signed [W:0] s);
        logic signed [W-1:0] r;
        if (s[W] != s[W-1]) begin
            r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            r = s[W-1:0];
        end
        sat = r;
    endfunction

    always_comb begin
        diff = sat({r_zr2[W-1], r_zr2} - {r_zi2[W-1], r_zi2});
        n_zr = sat({diff[W-1], diff} + {r_cr[W-1], r_cr});
        n_zi = sat({r_zri[W-1], r_zri} + {r_ci[W-1], r_ci});
    end

    // both squares are non-negative, so the sum is exact in W+1 bits
    assign mag2 = CMP_W'({1'b0, r_zr2} + {1'b0, r_zi2});
    assign o_sts.escape = (mag2 > BOUND);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr <= i_point.c_real;
            r_ci <= i_point.c_imag;
            r_zr <= i_point.c_real;
            r_zi <= i_point.c_imag;
        end
        if (i_cmd.mul) begin
            r_zr2 <= fx_mul(r_zr, r_zr, 1'b0);
            r_zi2 <= fx_mul(r_zi, r_zi, 1'b0);
            r_zri <= fx_mul(r_zr, r_zi, 1'b1);
        end
        if (i_cmd.add) begin
            r_zr <= n_zr;
            r_zi <= n_zi;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/met_ctrl.sv =====
// ----------------------------------------------------------------------------
// met_ctrl
// Controller: sequences seed squares, then add / square steps per iteration,
// counts iterations and registers the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module met_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [met_pkg::ITER_W-1:0] i_limit,
    input  wire met_pkg::t_dp_sts           i_sts,
    output met_pkg::t_dp_cmd                o_cmd,
    output logic                            o_busy,
    output logic                            o_done,
    output met_pkg::t_result                o_result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEED = 4'b0010,
        S_STEP = 4'b0100,
        S_SQR  = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [met_pkg::ITER_W-1:0]   r_iter, n_iter;
    logic                         r_done, n_done;
    met_pkg::t_result             r_result, n_result;

    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_done   = 1'b0;
        n_result = r_result;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_iter     = '0;
                    n_state    = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.mul = 1'b1;
                n_state   = S_STEP;
            end
            S_STEP: begin
                // squares in the datapath belong to iteration r_iter-1 (none after seed)
                if (r_iter != '0 && i_sts.escape) begin
                    n_done                   = 1'b1;
                    n_result.escaped         = 1'b1;
                    n_result.iteration_count = r_iter - 1'b1;
                    n_state                  = S_IDLE;
                end else if (r_iter == i_limit) begin
                    n_done                   = 1'b1;
                    n_result.escaped         = 1'b0;
                    n_result.iteration_count = '0;
                    n_state                  = S_IDLE;
                end else begin
                    o_cmd.add = 1'b1;
                    n_state   = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.mul = 1'b1;
                n_iter    = r_iter + 1'b1;
                n_state   = S_STEP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== hw/rtl/met_chk.sv =====
// ----------------------------------------------------------------------------
// met_chk
// Port-level checks on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module met_chk (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_done,
    input wire met_pkg::t_result o_result
);

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // the strobe only comes once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while still busy");

    // the strobe is never high in back-to-back cycles
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a point that stays inside reports count zero
    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.escaped) |-> (o_result.iteration_count == '0))
        else $error("non-escaped result with non-zero count");

endmodule

bind mandelbrot_escape_time_top met_chk u_met_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
